// File: rtl/core/caf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the complementary attitude filter.
package caf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int COUNT_WIDTH     = 24;

  localparam int DT_W   = 25;
  localparam int BW_W   = 17;
  localparam int CFG_W  = 25;
  localparam int IDX_W  = 1;

  localparam logic [DT_W-1:0] DT_RESET   = 25'd83886;
  localparam logic [BW_W-1:0] BW_RESET   = 17'd64225;
  localparam logic [BW_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic [IDX_W-1:0] REG_DT_STEP      = 1'b0;
  localparam logic [IDX_W-1:0] REG_BLEND_WEIGHT = 1'b1;

  localparam int SUM_W      = COUNT_WIDTH + 16;
  localparam int DVD_W      = SUM_W + 1;
  localparam int CTR_W      = $clog2(DVD_W + 1);
  localparam int SQRT_STEPS = 24;
  localparam int SQ_W       = 48;
  localparam int CW         = 28;
  localparam int CI_W       = $clog2(CORDIC_STEPS);
  localparam int MA_W       = 18;
  localparam int MB_W       = 33;
  localparam int P_W        = MA_W + MB_W;
  localparam int SAT_W      = P_W + 2;
  localparam int RATE_SHIFT = 28 - ANGLE_FRAC_BITS;
  localparam int RAD_FRAC   = 36;
  localparam longint unsigned DEG_PER_RAD_Q20 = 64'd60078979;

  localparam logic [31:0] NORM_LO = 32'd16777216;
  localparam logic [31:0] NORM_HI = 32'd150994944;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_UPDATE       = 3'd0,
    OP_BIAS_SAMPLE  = 3'd1,
    OP_BIAS_APPLY   = 3'd2,
    OP_BIAS_CLEAR   = 3'd3,
    OP_RESET_ANGLES = 3'd4,
    OP_SET_YAW      = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [15:0]  gyro_x;
    logic signed [15:0]  gyro_y;
    logic signed [15:0]  gyro_z;
    logic signed [15:0]  accel_x;
    logic signed [15:0]  accel_y;
    logic signed [15:0]  accel_z;
    logic signed [31:0]  yaw_init;
  } caf_in_t;

  typedef struct packed {
    logic signed [31:0] yaw_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic               is_started;
    logic               accel_used;
  } caf_out_t;

  typedef struct packed {
    logic             load;
    logic             rate;
    logic             norm;
    logic             gate;
    logic             sqrt;
    logic             pinit;
    logic             cordic;
    logic             blend;
    logic             misc;
    logic             dinit;
    logic             div;
    logic             dstore;
    logic             finish;
    logic [CTR_W-1:0] ctr;
    logic [1:0]       axis;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       gate_ok;
    logic       count_zero;
    logic       out_free;
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v[SAT_W-1]) begin
      r = (&v[SAT_W-2:31]) ? v[31:0] : 32'sh8000_0000;
    end else begin
      r = (|v[SAT_W-2:31]) ? 32'sh7FFF_FFFF : v[31:0];
    end
    return r;
  endfunction

  // long division of constants, shift and subtract
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, angle format, from a truncated series in Q36 radians
  function automatic logic [31:0] atan_step(input int i);
    longint unsigned rad;
    longint unsigned term;
    longint unsigned prod;
    int k;
    rad = 64'd0;
    if (i == 0) begin
      return 32'(45 << ANGLE_FRAC_BITS);
    end
    for (k = 0; i * (2 * k + 1) <= RAD_FRAC; k++) begin
      term = const_div(64'd1 << (RAD_FRAC - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) begin
        rad = rad - term;
      end else begin
        rad = rad + term;
      end
    end
    prod = rad * DEG_PER_RAD_Q20;
    prod = prod + (64'd1 << (55 - ANGLE_FRAC_BITS));
    return 32'(prod >> (56 - ANGLE_FRAC_BITS));
  endfunction

endpackage

// File: rtl/core/caf_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the complementary attitude filter.
module caf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  caf_pkg::st_t  st,
  output caf_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DECODE = 13'b0000000000010,
    ST_RATE   = 13'b0000000000100,
    ST_NORM   = 13'b0000000001000,
    ST_GATE   = 13'b0000000010000,
    ST_SQRT   = 13'b0000000100000,
    ST_PINIT  = 13'b0000001000000,
    ST_CORDIC = 13'b0000010000000,
    ST_BLEND  = 13'b0000100000000,
    ST_DINIT  = 13'b0001000000000,
    ST_DIV    = 13'b0010000000000,
    ST_DSTORE = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [caf_pkg::CTR_W-1:0] ctr_r, ctr_nxt;
  logic [1:0]                axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r + caf_pkg::CTR_W'(1);
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.ctr   = ctr_r;
    cmd.axis  = axis_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctr_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctr_nxt  = '0;
        axis_nxt = 2'd0;
        case (caf_pkg::op_t'(st.op))
          caf_pkg::OP_UPDATE: state_nxt = ST_RATE;
          caf_pkg::OP_BIAS_APPLY: state_nxt = st.count_zero ? ST_DONE : ST_DINIT;
          default: begin
            cmd.misc  = 1'b1;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_RATE: begin
        cmd.rate = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(5)) begin
          ctr_nxt   = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(5)) begin
          ctr_nxt   = '0;
          state_nxt = ST_GATE;
        end
      end
      ST_GATE: begin
        cmd.gate  = 1'b1;
        ctr_nxt   = '0;
        state_nxt = st.gate_ok ? ST_SQRT : ST_DONE;
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(caf_pkg::SQRT_STEPS - 1)) begin
          ctr_nxt   = '0;
          state_nxt = ST_PINIT;
        end
      end
      ST_PINIT: begin
        cmd.pinit = 1'b1;
        ctr_nxt   = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(caf_pkg::CORDIC_STEPS - 1)) begin
          ctr_nxt   = '0;
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(4)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DINIT: begin
        cmd.dinit = 1'b1;
        ctr_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (ctr_r == caf_pkg::CTR_W'(caf_pkg::DVD_W - 1)) begin
          state_nxt = ST_DSTORE;
        end
      end
      ST_DSTORE: begin
        cmd.dstore = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_DINIT;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctr_r   <= '0;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      axis_r  <= axis_nxt;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> st.out_free)
    else $error("result loaded while output register still full");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("transfer not followed by decode");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC) |-> (ctr_r < caf_pkg::CTR_W'(caf_pkg::CORDIC_STEPS)))
    else $error("CORDIC step count overrun");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != 2'd3)
    else $error("bias axis out of range");

endmodule

// File: rtl/core/caf_dp.sv
`timescale 1ns / 1ps
// Datapath of the complementary attitude filter: shared multiplier, CORDIC, square root, divider.
module caf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  caf_pkg::caf_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [caf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [caf_pkg::CFG_W-1:0]   cfg_data,
  input  caf_pkg::cmd_t               cmd,
  output caf_pkg::st_t                st,
  output logic                        out_valid,
  input  logic                        out_ready,
  output caf_pkg::caf_out_t           out_data
);

  localparam int CW    = caf_pkg::CW;
  localparam int P_W   = caf_pkg::P_W;
  localparam int SAT_W = caf_pkg::SAT_W;
  localparam int SQ_W  = caf_pkg::SQ_W;
  localparam int NCW   = caf_pkg::COUNT_WIDTH;
  localparam int SUM_W = caf_pkg::SUM_W;
  localparam int DVD_W = caf_pkg::DVD_W;

  localparam logic signed [SAT_W-1:0] RATE_HALF  = SAT_W'(1) << (caf_pkg::RATE_SHIFT - 1);
  localparam logic signed [SAT_W-1:0] BLEND_HALF = SAT_W'(1) << 15;
  localparam logic signed [31:0]      ANG_HALF   = 32'sd180 <<< caf_pkg::ANGLE_FRAC_BITS;
  localparam logic [SQ_W-1:0]         SQ_BIT0    = SQ_W'(1) << (SQ_W - 2);

  // configuration and filter state
  logic [caf_pkg::DT_W-1:0]  dt_r;
  logic [caf_pkg::BW_W-1:0]  bw_r;
  logic signed [31:0]        yaw_r, pitch_r, roll_r;
  logic signed [15:0]        bias_r [3];
  logic signed [SUM_W-1:0]   sum_r [3];
  logic [NCW-1:0]            count_r;
  logic                      started_r;
  logic                      out_valid_r;

  // working registers
  caf_pkg::caf_in_t          in_r;
  caf_pkg::caf_out_t         out_r;
  logic                      used_r;
  logic signed [P_W-1:0]     prod_r, acc_r;
  logic signed [31:0]        roll_g_r, pitch_g_r, roll_a_r;
  logic [31:0]               n2_r, yz_r;
  logic signed [CW-1:0]      cx_r, cy_r;
  logic signed [31:0]        cz_r;
  logic [SQ_W-1:0]           sq_n_r, sq_root_r, sq_bit_r;
  logic [DVD_W-1:0]          dvd_r;
  logic [NCW-1:0]            rem_r;
  logic                      neg_r;

  logic [31:0] atan_tab [caf_pkg::CORDIC_STEPS];
  for (genvar k = 0; k < caf_pkg::CORDIC_STEPS; k++) begin : g_atan
    localparam logic [31:0] ATAN_K = caf_pkg::atan_step(k);
    assign atan_tab[k] = ATAN_K;
  end

  // shared multiplier operands
  logic signed [15:0]         g_sel, b_sel, a_sel;
  logic signed [16:0]         g_diff;
  logic [caf_pkg::BW_W-1:0]   w_eff, w_inv;
  logic signed [caf_pkg::MA_W-1:0] mul_a;
  logic signed [caf_pkg::MB_W-1:0] mul_b;
  logic signed [P_W-1:0]      prod_nxt;

  always_comb begin
    case (cmd.ctr[2:1])
      2'd0: begin g_sel = in_r.gyro_x; b_sel = bias_r[0]; a_sel = in_r.accel_y; end
      2'd1: begin g_sel = in_r.gyro_y; b_sel = bias_r[1]; a_sel = in_r.accel_z; end
      default: begin g_sel = in_r.gyro_z; b_sel = bias_r[2]; a_sel = in_r.accel_x; end
    endcase
    g_diff = 17'(g_sel) - 17'(b_sel);
    w_eff  = (bw_r > caf_pkg::WEIGHT_ONE) ? caf_pkg::WEIGHT_ONE : bw_r;
    w_inv  = caf_pkg::WEIGHT_ONE - w_eff;
    if (cmd.rate) begin
      mul_a = caf_pkg::MA_W'(g_diff);
      mul_b = $signed({8'd0, dt_r});
    end else if (cmd.norm) begin
      mul_a = caf_pkg::MA_W'(a_sel);
      mul_b = caf_pkg::MB_W'(a_sel);
    end else begin
      case (cmd.ctr[1:0])
        2'd0: begin mul_a = $signed({1'b0, w_eff}); mul_b = caf_pkg::MB_W'(roll_g_r); end
        2'd1: begin mul_a = $signed({1'b0, w_inv}); mul_b = caf_pkg::MB_W'(roll_a_r); end
        2'd2: begin mul_a = $signed({1'b0, w_eff}); mul_b = caf_pkg::MB_W'(pitch_g_r); end
        default: begin mul_a = $signed({1'b0, w_inv}); mul_b = caf_pkg::MB_W'(cz_r); end
      endcase
    end
  end

  assign prod_nxt = mul_a * mul_b;

  // rate integration and blend rounding
  logic signed [31:0]      ang_sel, ang_sat, blend_sat;
  logic signed [SAT_W-1:0] inc, ang_sum, blend_sum;

  always_comb begin
    case (cmd.ctr[2:1])
      2'd0:    ang_sel = roll_r;
      2'd1:    ang_sel = pitch_r;
      default: ang_sel = yaw_r;
    endcase
    inc       = (SAT_W'(prod_r) + RATE_HALF) >>> caf_pkg::RATE_SHIFT;
    ang_sum   = SAT_W'(ang_sel) + inc;
    ang_sat   = caf_pkg::sat32(ang_sum);
    blend_sum = (SAT_W'(acc_r) + SAT_W'(prod_r) + BLEND_HALF) >>> 16;
    blend_sat = caf_pkg::sat32(blend_sum);
  end

  // CORDIC start values and one rotation
  logic signed [CW-1:0] ci_x, ci_y, cn_x, cn_y;
  logic signed [31:0]   ci_z, cn_z;
  logic                 cord_run;

  always_comb begin
    if (cmd.pinit) begin
      ci_y = -(CW'(in_r.accel_x) <<< 8);
      ci_x = $signed(sq_root_r[CW-1:0]);
    end else begin
      ci_y = CW'(in_r.accel_y) <<< 8;
      ci_x = CW'(in_r.accel_z) <<< 8;
    end
    ci_z = 32'sd0;
    if (ci_x < 0) begin
      ci_z = (ci_y >= 0) ? ANG_HALF : -ANG_HALF;
      ci_x = -ci_x;
      ci_y = -ci_y;
    end
    cn_x = cx_r;
    cn_y = cy_r;
    cn_z = cz_r;
    if (cy_r != '0) begin
      if (!cy_r[CW-1]) begin
        cn_x = cx_r + (cy_r >>> cmd.ctr);
        cn_y = cy_r - (cx_r >>> cmd.ctr);
        cn_z = cz_r + $signed(atan_tab[cmd.ctr[caf_pkg::CI_W-1:0]]);
      end else begin
        cn_x = cx_r - (cy_r >>> cmd.ctr);
        cn_y = cy_r + (cx_r >>> cmd.ctr);
        cn_z = cz_r - $signed(atan_tab[cmd.ctr[caf_pkg::CI_W-1:0]]);
      end
    end
  end

  assign cord_run = cmd.cordic ||
                    (cmd.sqrt && (cmd.ctr < caf_pkg::CTR_W'(caf_pkg::CORDIC_STEPS)));

  // square root step
  logic [SQ_W-1:0] sq_t;
  assign sq_t = sq_root_r + sq_bit_r;

  // divider step, bias apply setup and store
  logic [NCW:0]           trial;
  logic                   q_bit;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]       mag;
  logic signed [15:0]     bias_q;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    q_bit = (trial >= {1'b0, count_r});
    case (cmd.axis)
      2'd0:    sum_sel = sum_r[0];
      2'd1:    sum_sel = sum_r[1];
      default: sum_sel = sum_r[2];
    endcase
    mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    if (neg_r) begin
      bias_q = (dvd_r > DVD_W'(32768)) ? 16'sh8000 : $signed(16'(~dvd_r[15:0] + 16'd1));
    end else begin
      bias_q = (dvd_r > DVD_W'(32767)) ? 16'sh7FFF : $signed(dvd_r[15:0]);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r        <= caf_pkg::DT_RESET;
      bw_r        <= caf_pkg::BW_RESET;
      yaw_r       <= '0;
      pitch_r     <= '0;
      roll_r      <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        bias_r[j] <= '0;
        sum_r[j]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          caf_pkg::REG_DT_STEP:      dt_r <= cfg_data[caf_pkg::DT_W-1:0];
          caf_pkg::REG_BLEND_WEIGHT: bw_r <= cfg_data[caf_pkg::BW_W-1:0];
          default: ;
        endcase
      end
      if (cmd.rate && cmd.ctr[0] && (cmd.ctr[2:1] == 2'd2)) begin
        yaw_r <= ang_sat;
      end
      if (cmd.gate) begin
        started_r <= 1'b1;
        if (!st.gate_ok) begin
          roll_r  <= roll_g_r;
          pitch_r <= pitch_g_r;
        end
      end
      if (cmd.blend && (cmd.ctr == caf_pkg::CTR_W'(2))) begin
        roll_r <= blend_sat;
      end
      if (cmd.blend && (cmd.ctr == caf_pkg::CTR_W'(4))) begin
        pitch_r <= blend_sat;
      end
      if (cmd.misc) begin
        case (caf_pkg::op_t'(in_r.op))
          caf_pkg::OP_BIAS_SAMPLE: begin
            if (count_r != caf_pkg::COUNT_MAX) begin
              sum_r[0] <= sum_r[0] + SUM_W'(in_r.gyro_x);
              sum_r[1] <= sum_r[1] + SUM_W'(in_r.gyro_y);
              sum_r[2] <= sum_r[2] + SUM_W'(in_r.gyro_z);
              count_r  <= count_r + NCW'(1);
            end
          end
          caf_pkg::OP_BIAS_CLEAR: begin
            for (int j = 0; j < 3; j++) begin
              sum_r[j] <= '0;
            end
            count_r <= '0;
          end
          caf_pkg::OP_RESET_ANGLES: begin
            yaw_r     <= '0;
            pitch_r   <= '0;
            roll_r    <= '0;
            started_r <= 1'b0;
          end
          caf_pkg::OP_SET_YAW: yaw_r <= in_r.yaw_init;
          default: ;
        endcase
      end
      if (cmd.dstore) begin
        case (cmd.axis)
          2'd0:    bias_r[0] <= bias_q;
          2'd1:    bias_r[1] <= bias_q;
          default: bias_r[2] <= bias_q;
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      in_r   <= in_data;
      used_r <= 1'b0;
      n2_r   <= '0;
      yz_r   <= '0;
    end
    if (cmd.rate && cmd.ctr[0]) begin
      case (cmd.ctr[2:1])
        2'd0:    roll_g_r  <= ang_sat;
        2'd1:    pitch_g_r <= ang_sat;
        default: ;
      endcase
    end
    if (cmd.norm && cmd.ctr[0]) begin
      n2_r <= n2_r + prod_r[31:0];
      if (cmd.ctr[2:1] != 2'd2) begin
        yz_r <= yz_r + prod_r[31:0];
      end
    end
    if (cmd.gate && st.gate_ok) begin
      used_r    <= 1'b1;
      sq_n_r    <= {yz_r, 16'd0};
      sq_root_r <= '0;
      sq_bit_r  <= SQ_BIT0;
    end
    if (cmd.gate || cmd.pinit) begin
      cx_r <= ci_x;
      cy_r <= ci_y;
      cz_r <= ci_z;
    end else if (cord_run) begin
      cx_r <= cn_x;
      cy_r <= cn_y;
      cz_r <= cn_z;
    end
    if (cmd.pinit) begin
      roll_a_r <= cz_r;
    end
    if (cmd.sqrt) begin
      if (sq_n_r >= sq_t) begin
        sq_n_r    <= sq_n_r - sq_t;
        sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.blend && cmd.ctr[0]) begin
      acc_r <= prod_r;
    end
    if (cmd.dinit) begin
      neg_r <= sum_sel[SUM_W-1];
      dvd_r <= DVD_W'(mag) + DVD_W'(count_r >> 1);
      rem_r <= '0;
    end
    if (cmd.div) begin
      rem_r <= q_bit ? NCW'(trial - {1'b0, count_r}) : trial[NCW-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
    end
    if (cmd.finish) begin
      out_r.yaw_angle   <= yaw_r;
      out_r.pitch_angle <= pitch_r;
      out_r.roll_angle  <= roll_r;
      out_r.is_started  <= started_r;
      out_r.accel_used  <= used_r;
    end
  end

  assign st.op         = in_r.op;
  assign st.gate_ok    = (n2_r > caf_pkg::NORM_LO) && (n2_r < caf_pkg::NORM_HI);
  assign st.count_zero = (count_r == '0);
  assign st.out_free   = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// File: rtl/core/complementary_attitude_filter.sv
`timescale 1ns / 1ps
// Top level of the six-axis complementary attitude filter.
// One item at a time; the next transfer is taken once the result sits in the output register.
// Update with accel blend: shared multiplier, 24-step root, then CORDIC_STEPS rotations;
// update gyro only skips the root and the rotations.
// Bias apply: one divide per axis, one quotient bit per cycle, none with no samples.
// Synchronous reset clears angles, bias state and started flag and loads default registers.
module complementary_attitude_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  caf_pkg::caf_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output caf_pkg::caf_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [caf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [caf_pkg::CFG_W-1:0]   cfg_data
);

  caf_pkg::cmd_t cmd;
  caf_pkg::st_t  st;

  caf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  caf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
